### rtl/grayscale_erosion_nonflat_core_defines.svh
// Assertion macros shared by the erosion core RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef GRAYSCALE_EROSION_NONFLAT_CORE_DEFINES_SVH
`define GRAYSCALE_EROSION_NONFLAT_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define GERO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define GERO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/gero_pkg.sv
// Shared types and constants of the grayscale erosion core.
// No dependencies.
package gero_pkg;

  localparam int unsigned MaxWidthDef   = 1024;
  localparam int unsigned MaxElementDef = 7;

  localparam logic [10:0] ImgWidthRst   = 11'd1024;
  localparam logic [15:0] ImgHeightRst  = 16'd1024;
  localparam logic [2:0]  ElemWidthRst  = 3'd3;
  localparam logic [2:0]  ElemHeightRst = 3'd3;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_IMG_WIDTH   = 2'd0,
    REG_IMG_HEIGHT  = 2'd1,
    REG_ELEM_WIDTH  = 2'd2,
    REG_ELEM_HEIGHT = 2'd3
  } reg_e;

endpackage

### rtl/grayscale_erosion_nonflat_core.sv
// Top level of the grayscale erosion core with a signed non-flat element.
// Depends on gero_pkg, gero_ram and grayscale_erosion_nonflat_core_defines.svh.
//
// Load words (command 0) fill the element table, and load and no-op words are
// accepted without leaving the idle state. A pixel or flush word whose window
// completes runs from its accept to the next accept through the accept in
// S_IDLE, the bounds and readiness setup in S_MULT, S_CMP and S_SETUP, one
// window entry per cycle in S_RUN read from the line store RAM and the element
// RAM through their single read ports, S_DRAIN that folds in the last read, and
// S_FIN that hands the result to the output register. A pixel or flush word
// with no complete window returns to idle after S_MULT and S_CMP. A result
// waiting in the output register holds the next window in its final cycle
// until the register drains. A configuration write restarts the frame.
`include "grayscale_erosion_nonflat_core_defines.svh"

module grayscale_erosion_nonflat_core #(
  parameter int unsigned MAX_WIDTH   = gero_pkg::MaxWidthDef,
  parameter int unsigned MAX_ELEMENT = gero_pkg::MaxElementDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [2:0]         element_row_i,
  input  logic [2:0]         element_col_i,
  input  logic signed [15:0] element_value_i,
  input  logic [7:0]         pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         eroded_o,
  output logic               last_of_frame_o
);
  import gero_pkg::*;

  localparam int unsigned Depth  = MAX_ELEMENT * MAX_WIDTH;
  localparam int unsigned AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned EDepth = MAX_ELEMENT * MAX_ELEMENT;
  localparam int unsigned EAW    = (EDepth > 1) ? $clog2(EDepth) : 1;
  localparam int unsigned EIW    = $clog2(MAX_ELEMENT + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MULT  = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_SETUP = 7'b0001000,
    S_RUN   = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q;

  logic [10:0] img_w_q;
  logic [15:0] img_h_q;
  logic [2:0]  elem_w_q, elem_h_q;

  logic [10:0]    w;
  logic [15:0]    h;
  logic [EIW-1:0] ew, eh, cx, cy;

  assign w  = (img_w_q == '0) ? 11'd1 :
              (32'(img_w_q) > MAX_WIDTH) ? 11'(MAX_WIDTH) : img_w_q;
  assign h  = (img_h_q == '0) ? 16'd1 : img_h_q;
  assign ew = (elem_w_q == '0) ? EIW'(1) :
              (32'(elem_w_q) > MAX_ELEMENT) ? EIW'(MAX_ELEMENT) : EIW'(elem_w_q);
  assign eh = (elem_h_q == '0) ? EIW'(1) :
              (32'(elem_h_q) > MAX_ELEMENT) ? EIW'(MAX_ELEMENT) : EIW'(elem_h_q);
  assign cx = EIW'((32'(ew) + 1) >> 1);
  assign cy = EIW'((32'(eh) + 1) >> 1);

  logic [25:0]   in_cnt_q, out_cnt_q;
  logic [AW-1:0] wptr_q, optr_q;
  logic [15:0]   out_row_q;
  logic [10:0]   out_col_q;
  logic          is_pixel_q;
  logic [7:0]    pix_q;
  logic [26:0]   total_q, prod_q;
  logic [10:0]   nc_q;

  logic signed [17:0] sr_q;
  logic signed [12:0] sc_q, sc_start_q;
  logic [AW-1:0]      row_addr_q, col_addr_q;
  logic [EIW-1:0]     jj_q, ii_q;
  logic [EAW-1:0]     ebase_q;
  logic               v1_q, have_q;
  logic signed [17:0] best_q;

  logic       out_valid_q, out_last_q;
  logic [7:0] out_pix_q;

  logic accept;
  assign in_ready_o = (state_q == S_IDLE) && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;

  // Element and line store RAMs.
  logic           e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [15:0]    e_rdata;
  logic           p_we;
  logic [7:0]     p_rdata;

  assign e_we    = accept && (command_i == CMD_LOAD) &&
                   (32'(element_row_i) < MAX_ELEMENT) && (32'(element_col_i) < MAX_ELEMENT);
  assign e_waddr = EAW'(32'(element_row_i) * MAX_ELEMENT + 32'(element_col_i));
  assign e_raddr = ebase_q + EAW'(ii_q);

  gero_ram #(.WIDTH(16), .DEPTH(EDepth)) u_elem_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(element_value_i),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  logic in_room;
  assign in_room = (27'(in_cnt_q) < total_q);
  assign p_we    = (state_q == S_CMP) && is_pixel_q && in_room;

  gero_ram #(.WIDTH(8), .DEPTH(Depth)) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(wptr_q),
    .wdata_i(pix_q),
    .raddr_i(col_addr_q),
    .rdata_o(p_rdata)
  );

  // Window bounds and readiness.
  logic [16:0] nr_full;
  logic [15:0] nr;
  logic [11:0] nc_full;
  logic [10:0] nc;
  logic [25:0] in_cnt_new;
  logic        win_ready;

  assign nr_full    = 17'(out_row_q) + 17'(cy) - 17'd1;
  assign nr         = (nr_full > 17'(h) - 17'd1) ? h - 16'd1 : nr_full[15:0];
  assign nc_full    = 12'(out_col_q) + 12'(cx) - 12'd1;
  assign nc         = (nc_full > 12'(w) - 12'd1) ? w - 11'd1 : nc_full[10:0];
  assign in_cnt_new = p_we ? in_cnt_q + 26'd1 : in_cnt_q;
  assign win_ready  = (27'(out_cnt_q) < total_q) &&
                      (28'(in_cnt_new) > 28'(prod_q) + 28'(nc_q));

  // Address arithmetic modulo the line store depth.
  logic [AW:0] off, row_start, row_next, ww, dd;
  assign dd        = (AW+1)'(Depth);
  assign ww        = (AW+1)'(w);
  assign off       = (AW+1)'(cy - EIW'(1)) * ww + (AW+1)'(cx - EIW'(1));
  assign row_start = ({1'b0, optr_q} + off >= dd) ? {1'b0, optr_q} + off - dd
                                                  : {1'b0, optr_q} + off;
  assign row_next  = ({1'b0, row_addr_q} >= ww) ? {1'b0, row_addr_q} - ww
                                                : {1'b0, row_addr_q} + dd - ww;

  logic sr_ok, sc_ok;
  assign sr_ok = !sr_q[17] && (sr_q[16:0] < 17'(h));
  assign sc_ok = !sc_q[12] && (sc_q[11:0] < 12'(w));

  logic signed [17:0] diff;
  assign diff = 18'(signed'({1'b0, p_rdata})) - 18'($signed(e_rdata));

  logic row_end, last_cell, frame_last;
  assign row_end    = (ii_q == ew - EIW'(1));
  assign last_cell  = row_end && (jj_q == eh - EIW'(1));
  assign frame_last = (27'(out_cnt_q) + 27'd1 == total_q);

  logic can_emit;
  assign can_emit = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      img_w_q     <= ImgWidthRst;
      img_h_q     <= ImgHeightRst;
      elem_w_q    <= ElemWidthRst;
      elem_h_q    <= ElemHeightRst;
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      wptr_q      <= '0;
      optr_q      <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      v1_q        <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_index_i))
          REG_IMG_WIDTH:   img_w_q  <= cfg_data_i[10:0];
          REG_IMG_HEIGHT:  img_h_q  <= cfg_data_i;
          REG_ELEM_WIDTH:  elem_w_q <= cfg_data_i[2:0];
          REG_ELEM_HEIGHT: elem_h_q <= cfg_data_i[2:0];
          default: ;
        endcase
        in_cnt_q  <= '0;
        out_cnt_q <= '0;
        wptr_q    <= '0;
        optr_q    <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
      end
      v1_q <= (state_q == S_RUN) && sr_ok && sc_ok;
      if (v1_q) begin
        have_q <= 1'b1;
        if (!have_q || diff < best_q) begin
          best_q <= diff;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (command_i == CMD_PIXEL || command_i == CMD_FLUSH)) begin
            is_pixel_q <= (command_i == CMD_PIXEL);
            pix_q      <= pixel_i;
            state_q    <= S_MULT;
          end
        end
        S_MULT: begin
          total_q <= 27'(h) * 27'(w);
          prod_q  <= 27'(nr) * 27'(w);
          nc_q    <= nc;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (p_we) begin
            in_cnt_q <= in_cnt_new;
            wptr_q   <= (32'(wptr_q) == Depth - 1) ? '0 : wptr_q + AW'(1);
          end
          state_q <= win_ready ? S_SETUP : S_IDLE;
        end
        S_SETUP: begin
          sr_q       <= $signed(18'(out_row_q)) + $signed(18'(cy)) - 18'sd1;
          sc_q       <= $signed(13'(out_col_q)) + $signed(13'(cx)) - 13'sd1;
          sc_start_q <= $signed(13'(out_col_q)) + $signed(13'(cx)) - 13'sd1;
          row_addr_q <= row_start[AW-1:0];
          col_addr_q <= row_start[AW-1:0];
          jj_q       <= '0;
          ii_q       <= '0;
          ebase_q    <= '0;
          have_q     <= 1'b0;
          state_q    <= S_RUN;
        end
        S_RUN: begin
          if (row_end) begin
            ii_q       <= '0;
            jj_q       <= jj_q + EIW'(1);
            sc_q       <= sc_start_q;
            sr_q       <= sr_q - 18'sd1;
            ebase_q    <= ebase_q + EAW'(MAX_ELEMENT);
            row_addr_q <= row_next[AW-1:0];
            col_addr_q <= row_next[AW-1:0];
          end else begin
            ii_q       <= ii_q + EIW'(1);
            sc_q       <= sc_q - 13'sd1;
            col_addr_q <= (col_addr_q == '0) ? AW'(Depth - 1) : col_addr_q - AW'(1);
          end
          if (last_cell) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_last_q  <= frame_last;
            out_pix_q   <= best_q[17] ? 8'd0 :
                           (best_q > 18'sd255) ? 8'd255 : best_q[7:0];
            if (frame_last) begin
              in_cnt_q  <= '0;
              out_cnt_q <= '0;
              wptr_q    <= '0;
              optr_q    <= '0;
              out_row_q <= '0;
              out_col_q <= '0;
            end else begin
              out_cnt_q <= out_cnt_q + 26'd1;
              optr_q    <= (32'(optr_q) == Depth - 1) ? '0 : optr_q + AW'(1);
              if (out_col_q == w - 11'd1) begin
                out_col_q <= '0;
                out_row_q <= out_row_q + 16'd1;
              end else begin
                out_col_q <= out_col_q + 11'd1;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign eroded_o        = out_pix_q;
  assign last_of_frame_o = out_last_q;

  `GERO_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")
  `GERO_ASSERT(a_out_behind_in, out_cnt_q <= in_cnt_q, "output count passed input count")
  `GERO_ASSERT_IMP(a_run_in_frame, state_q == S_RUN, 27'(out_cnt_q) < total_q,
                   "window started past end of frame")
  `GERO_ASSERT_IMP(a_fin_has_min, state_q == S_FIN, have_q,
                   "window finished without any in-image entry")

endmodule

### rtl/gero_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gero_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/sv/grayscale_erosion_nonflat_core_test.sv
// Testbench for grayscale_erosion_nonflat_core: a scoreboard class predicts every
// eroded word from the accepted input words, and plain tasks drive the core.
// Depends on gero_pkg and the core RTL.
`timescale 1ns / 1ps

module grayscale_erosion_nonflat_core_test;
  import gero_pkg::*;

  localparam int unsigned TableDim   = 7;
  localparam int unsigned StoreDepth = 7 * 1024;
  localparam int unsigned SettleCyc  = 60;
  localparam int unsigned StallLimit = 5000;

  typedef struct packed {
    logic [7:0] eroded;
    logic       last;
  } erosion_word_t;

  class erosion_scoreboard;
    logic signed [15:0] weights [0:TableDim*TableDim-1];
    logic [7:0]         lines [0:StoreDepth-1];
    int unsigned        in_cnt, out_cnt;
    int unsigned        img_w, img_h, elem_w, elem_h;
    erosion_word_t      pending [$];
    int unsigned        errors, results, frames;

    function new();
      in_cnt = 0; out_cnt = 0;
      img_w = ImgWidthRst; img_h = ImgHeightRst;
      elem_w = ElemWidthRst; elem_h = ElemHeightRst;
      errors = 0; results = 0; frames = 0;
    endfunction

    function int unsigned fit(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(reg_e idx, logic [15:0] data);
      case (idx)
        REG_IMG_WIDTH:   img_w = data[10:0];
        REG_IMG_HEIGHT:  img_h = data;
        REG_ELEM_WIDTH:  elem_w = data[2:0];
        REG_ELEM_HEIGHT: elem_h = data[2:0];
      endcase
      in_cnt = 0;
      out_cnt = 0;
    endfunction

    function logic [7:0] erode_at(int unsigned k, int unsigned w, int unsigned h,
                                  int unsigned ew, int unsigned eh);
      int r, c, cy, cx, sr, sc, v, best;
      r = k / w; c = k % w;
      cy = (eh + 1) / 2; cx = (ew + 1) / 2;
      best = 32'h7fffffff;
      for (int jj = 0; jj < eh; jj++) begin
        sr = r + cy - 1 - jj;
        if (sr < 0 || sr >= h) continue;
        for (int ii = 0; ii < ew; ii++) begin
          sc = c + cx - 1 - ii;
          if (sc < 0 || sc >= w) continue;
          v = int'(lines[(sr * w + sc) % StoreDepth]) - int'(weights[jj * TableDim + ii]);
          if (v < best) best = v;
        end
      end
      if (best < 0) return 8'd0;
      if (best > 255) return 8'd255;
      return best[7:0];
    endfunction

    function bit note_input(cmd_e cmd, logic [2:0] row, logic [2:0] col,
                            logic [15:0] val, logic [7:0] pix);
      int unsigned w, h, ew, eh, total, r, c, nr, nc;
      erosion_word_t ew_word;
      if (cmd == CMD_LOAD) begin
        if (row < TableDim && col < TableDim) weights[row * TableDim + col] = val;
        return 0;
      end
      if (cmd == CMD_NOP) return 0;
      w = fit(img_w, 1024); h = fit(img_h, 65535);
      ew = fit(elem_w, TableDim); eh = fit(elem_h, TableDim);
      total = w * h;
      if (cmd == CMD_PIXEL && in_cnt < total) begin
        lines[in_cnt % StoreDepth] = pix;
        in_cnt++;
      end
      if (out_cnt >= total) return 0;
      r = out_cnt / w; c = out_cnt % w;
      nr = r + (eh + 1) / 2 - 1; nc = c + (ew + 1) / 2 - 1;
      if (nr > h - 1) nr = h - 1;
      if (nc > w - 1) nc = w - 1;
      if (!(in_cnt > nr * w + nc)) return 0;
      ew_word.eroded = erode_at(out_cnt, w, h, ew, eh);
      ew_word.last = (out_cnt + 1 == total);
      pending.push_back(ew_word);
      out_cnt++;
      if (ew_word.last) begin
        in_cnt = 0;
        out_cnt = 0;
        frames++;
      end
      return 1;
    endfunction

    function void check_result(logic [7:0] eroded, logic last);
      erosion_word_t want;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word eroded=%0d last=%0b", $time, eroded, last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (eroded !== want.eroded) begin
        $display("%0t: eroded expected %0d actual %0d", $time, want.eroded, eroded);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_of_frame expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         command_i = '0;
  logic [2:0]         element_row_i = '0;
  logic [2:0]         element_col_i = '0;
  logic signed [15:0] element_value_i = '0;
  logic [7:0]         pixel_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         eroded_o;
  logic               last_of_frame_o;

  erosion_scoreboard sb = new();
  bit          quiet;
  int unsigned words_sent, out_wait, idle_cycles, phases;

  grayscale_erosion_nonflat_core uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(eroded_o, last_of_frame_o);
      out_wait = quiet ? 0 : $urandom_range(0, 6);
    end
    if (out_wait > 0) begin
      out_ready_i <= 1'b0;
      out_wait--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("grayscale_erosion_nonflat_core: mismatch");
      $finish;
    end
  end

  task automatic send_word(cmd_e cmd, logic [2:0] row, logic [2:0] col,
                           logic [15:0] val, logic [7:0] pix, output bit got);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    element_row_i   <= row;
    element_col_i   <= col;
    element_value_i <= val;
    pixel_i         <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    got = sb.note_input(cmd, row, col, val, pix);
    words_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] ew, logic [15:0] eh);
    settle();
    write_reg(REG_IMG_WIDTH, w);
    write_reg(REG_IMG_HEIGHT, h);
    write_reg(REG_ELEM_WIDTH, ew);
    write_reg(REG_ELEM_HEIGHT, eh);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_weight();
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(0, 160)) - 80);
  endfunction

  // Push pixels with some noise, then drain; stop early when truncated.
  task automatic run_frame(int unsigned cap);
    int unsigned total, npx, pick;
    bit got;
    total = sb.fit(sb.img_w, 1024) * sb.fit(sb.img_h, 65535);
    npx = (cap < total) ? cap : total;
    for (int unsigned i = 0; i < npx; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) send_word(CMD_NOP, 3'($urandom()), 3'($urandom()), 16'($urandom()),
                               8'($urandom()), got);
      else if (pick == 1) send_word(CMD_FLUSH, 3'($urandom()), 3'($urandom()),
                                    16'($urandom()), 8'($urandom()), got);
      else if (pick == 2) send_word(CMD_LOAD, 3'($urandom()), 3'($urandom()),
                                    rand_weight(), 8'($urandom()), got);
      send_word(CMD_PIXEL, 3'($urandom()), 3'($urandom()), 16'($urandom()),
                8'($urandom()), got);
    end
    if (npx < total) return;
    while (sb.in_cnt != 0) begin
      send_word($urandom_range(0, 1) ? CMD_FLUSH : CMD_PIXEL, 3'($urandom()),
                3'($urandom()), 16'($urandom()), 8'($urandom()), got);
      if (!got) break;
    end
  endtask

  initial begin
    bit got;
    quiet = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(16'd4, 16'd3, 16'd3, 16'd3);
    for (int r = 0; r < TableDim; r++)
      for (int c = 0; c < TableDim; c++)
        send_word(CMD_LOAD, 3'(r), 3'(c), rand_weight(), 8'd0, got);
    send_word(CMD_LOAD, 3'd7, 3'd7, 16'h7fff, 8'd0, got);
    send_word(CMD_LOAD, 3'd7, 3'd0, 16'h8000, 8'd0, got);
    send_word(CMD_NOP, 3'd7, 3'd7, 16'hffff, 8'hff, got);
    send_word(CMD_FLUSH, 3'd0, 3'd0, 16'd0, 8'd0, got);
    send_word(CMD_PIXEL, 3'd0, 3'd0, 16'd0, 8'd0, got);
    send_word(CMD_PIXEL, 3'd0, 3'd0, 16'd0, 8'd255, got);
    send_word(CMD_LOAD, 3'd1, 3'd1, 16'h8000, 8'd0, got);
    send_word(CMD_PIXEL, 3'd0, 3'd0, 16'd0, 8'd128, got);
    send_word(CMD_LOAD, 3'd1, 3'd1, 16'h7fff, 8'd0, got);
    run_frame(100);
    send_word(CMD_LOAD, 3'd1, 3'd1, 16'd0, 8'd0, got);

    configure(16'd0, 16'd0, 16'd0, 16'd0);
    run_frame(10);
    configure(16'hffff, 16'd1, 16'd7, 16'd7);
    run_frame(40);
    configure(16'd1, 16'hffff, 16'd7, 16'd1);
    run_frame(30);
    configure(16'd1024, 16'd2, 16'd1, 16'd7);
    run_frame(20);

    while (words_sent < 900) begin
      phases++;
      configure({5'($urandom()), 11'($urandom_range(1, 10))}, 16'($urandom_range(1, 6)),
                {13'($urandom()), 3'($urandom())}, {13'($urandom()), 3'($urandom())});
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 4))
        send_word(CMD_LOAD, 3'($urandom()), 3'($urandom()), rand_weight(), 8'($urandom()), got);
      run_frame($urandom_range(0, 5) == 0 ? $urandom_range(1, 30) : 100);
    end

    settle();
    $display("covered %0d input words, %0d eroded words, %0d full frames, %0d random phases",
             words_sent, sb.results, sb.frames, phases);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("grayscale_erosion_nonflat_core: match");
    else
      $display("grayscale_erosion_nonflat_core: mismatch");
    $finish;
  end

endmodule
